[sv/ohlc_pkg.sv]
// ============================================================================
// ohlc_pkg
// Shared widths, constants and word types of the OHLC bar resampler.
// ============================================================================
package ohlc_pkg;

    localparam int TIME_BITS   = 40;
    localparam int PRICE_BITS  = 32;
    localparam int VOLUME_BITS = 48;
    localparam int IN_VOL_BITS = 32;
    localparam int IVL_BITS    = 31;

    localparam logic [IVL_BITS-1:0] IVL_RESET = IVL_BITS'(60);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [TIME_BITS-1:0]   bar_time;
        logic [PRICE_BITS-1:0]  open_price;
        logic [PRICE_BITS-1:0]  high_price;
        logic [PRICE_BITS-1:0]  low_price;
        logic [PRICE_BITS-1:0]  close_price;
        logic [IN_VOL_BITS-1:0] traded_volume;
        logic                   end_of_data;
    } bar_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   period_time;
        logic [PRICE_BITS-1:0]  agg_open;
        logic [PRICE_BITS-1:0]  agg_high;
        logic [PRICE_BITS-1:0]  agg_low;
        logic [PRICE_BITS-1:0]  agg_close;
        logic [VOLUME_BITS-1:0] agg_volume;
        logic                   series_done;
        logic                   run_last;
    } res_t;

endpackage

[sv/ohlc_merge.sv]
// ============================================================================
// ohlc_merge
// Running-bar state and the single-pass merge logic. Given the held input
// word it reports how many result words it makes (0..2) and commits the
// state update when fire is high.
// ============================================================================
module ohlc_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ohlc_pkg::IVL_BITS-1:0]       interval,
    input  ohlc_pkg::bar_t                      bar,
    input  logic                                fire,
    output logic [1:0]                          res_cnt,
    output ohlc_pkg::res_t                      res0,
    output ohlc_pkg::res_t                      res1
);

    localparam logic [ohlc_pkg::TIME_BITS-1:0]   TIME_MAX = '1;
    localparam logic [ohlc_pkg::VOLUME_BITS-1:0] VOL_MAX  = '1;

    logic                                open_reg,  open_next;
    logic [ohlc_pkg::TIME_BITS-1:0]      begin_reg, begin_next;
    logic [ohlc_pkg::TIME_BITS-1:0]      limit_reg, limit_next;
    logic [ohlc_pkg::PRICE_BITS-1:0]     ropen_reg, ropen_next;
    logic [ohlc_pkg::PRICE_BITS-1:0]     rhigh_reg, rhigh_next;
    logic [ohlc_pkg::PRICE_BITS-1:0]     rlow_reg,  rlow_next;
    logic [ohlc_pkg::PRICE_BITS-1:0]     rclose_reg, rclose_next;
    logic [ohlc_pkg::VOLUME_BITS-1:0]    rvol_reg,  rvol_next;

    logic                                pass;
    logic                                hit;
    logic                                emit_old;
    logic                                emit_sec;
    logic [ohlc_pkg::TIME_BITS:0]        lim_sum;
    logic [ohlc_pkg::VOLUME_BITS:0]      vol_sum;
    logic [ohlc_pkg::TIME_BITS-1:0]      lim_base;
    ohlc_pkg::res_t                      old_res;
    ohlc_pkg::res_t                      sec_res;

    always_comb begin
        pass = (interval == '0);
        hit  = open_reg && (bar.bar_time < limit_reg);

        lim_base = open_reg ? limit_reg : bar.bar_time;
        lim_sum  = {1'b0, lim_base} + (ohlc_pkg::TIME_BITS + 1)'(interval);
        vol_sum  = {1'b0, rvol_reg} + (ohlc_pkg::VOLUME_BITS + 1)'(bar.traded_volume);

        begin_next  = begin_reg;
        limit_next  = limit_reg;
        ropen_next  = bar.open_price;
        rhigh_next  = bar.high_price;
        rlow_next   = bar.low_price;
        rclose_next = bar.close_price;
        rvol_next   = ohlc_pkg::VOLUME_BITS'(bar.traded_volume);

        if (hit) begin
            ropen_next = ropen_reg;
            rhigh_next = (bar.high_price > rhigh_reg) ? bar.high_price : rhigh_reg;
            rlow_next  = (bar.low_price < rlow_reg) ? bar.low_price : rlow_reg;
            rvol_next  = vol_sum[ohlc_pkg::VOLUME_BITS] ? VOL_MAX
                                                        : vol_sum[ohlc_pkg::VOLUME_BITS-1:0];
        end else begin
            begin_next = lim_base;
            limit_next = lim_sum[ohlc_pkg::TIME_BITS] ? TIME_MAX
                                                      : lim_sum[ohlc_pkg::TIME_BITS-1:0];
        end

        open_next = pass ? 1'b0 : !bar.end_of_data;

        old_res.period_time = begin_reg;
        old_res.agg_open    = ropen_reg;
        old_res.agg_high    = rhigh_reg;
        old_res.agg_low     = rlow_reg;
        old_res.agg_close   = rclose_reg;
        old_res.agg_volume  = rvol_reg;
        old_res.series_done = 1'b0;
        old_res.run_last    = 1'b0;

        if (pass) begin
            sec_res.period_time = bar.bar_time;
            sec_res.agg_open    = bar.open_price;
            sec_res.agg_high    = bar.high_price;
            sec_res.agg_low     = bar.low_price;
            sec_res.agg_close   = bar.close_price;
            sec_res.agg_volume  = ohlc_pkg::VOLUME_BITS'(bar.traded_volume);
            sec_res.series_done = bar.end_of_data;
        end else begin
            sec_res.period_time = begin_next;
            sec_res.agg_open    = ropen_next;
            sec_res.agg_high    = rhigh_next;
            sec_res.agg_low     = rlow_next;
            sec_res.agg_close   = rclose_next;
            sec_res.agg_volume  = rvol_next;
            sec_res.series_done = 1'b1;
        end
        sec_res.run_last = 1'b1;

        emit_old = open_reg && (pass || !hit);
        emit_sec = pass || bar.end_of_data;
        res_cnt  = {1'b0, emit_old} + {1'b0, emit_sec};

        res0          = emit_old ? old_res : sec_res;
        res0.run_last = !(emit_old && emit_sec);
        res1          = sec_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
        end else if (fire) begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && !pass) begin
            begin_reg  <= begin_next;
            limit_reg  <= limit_next;
            ropen_reg  <= ropen_next;
            rhigh_reg  <= rhigh_next;
            rlow_reg   <= rlow_next;
            rclose_reg <= rclose_next;
            rvol_reg   <= rvol_next;
        end
    end

    a_eod_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && bar.end_of_data) |=> !open_reg)
        else $error("period still open after end of data");

    a_pass_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && pass) |=> !open_reg)
        else $error("period open in pass-through");

    a_two_needs_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_cnt == 2'd2) |-> open_reg)
        else $error("two results without an open period");

endmodule

[sv/ohlc_res_fifo.sv]
// ============================================================================
// ohlc_res_fifo
// Small result queue: takes up to two words per cycle, hands out one.
// ============================================================================
module ohlc_res_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [1:0]                       push_cnt,
    input  ohlc_pkg::res_t                   din0,
    input  ohlc_pkg::res_t                   din1,
    input  logic                             pop,
    output logic [ohlc_pkg::FIFO_CW-1:0]     count,
    output ohlc_pkg::res_t                   dout
);

    ohlc_pkg::res_t                   mem_reg [ohlc_pkg::FIFO_DEPTH];
    logic [ohlc_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ohlc_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ohlc_pkg::FIFO_CW-1:0]     cnt_reg,    cnt_next;
    logic [ohlc_pkg::FIFO_AW-1:0]     wr_ptr_p1;

    always_comb begin
        wr_ptr_p1   = wr_ptr_reg + ohlc_pkg::FIFO_AW'(1);
        wr_ptr_next = wr_ptr_reg + ohlc_pkg::FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + ohlc_pkg::FIFO_AW'(pop);
        cnt_next    = cnt_reg + ohlc_pkg::FIFO_CW'(push_cnt) - ohlc_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= din0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_p1] <= din1;
        end
    end

    assign count = cnt_reg;
    assign dout  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg + ohlc_pkg::FIFO_CW'(push_cnt)) <= ohlc_pkg::FIFO_CW'(ohlc_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cnt_reg != '0))
        else $error("result queue underflow");

endmodule

[sv/ohlc_bar_resampler_top.sv]
// ============================================================================
// ohlc_bar_resampler_top
// Merges a time-ordered stream of OHLCV bars into bars of a set interval.
// ============================================================================
// Input words (s_*) carry one price bar each; result words (m_*) carry
// finished aggregated bars. Both channels use valid/ready. cfg_wr_en with
// cfg_wr_data sets the interval in seconds (0 = pass-through); write it
// only while the block is idle.
// An accepted word is held in the input register, then the merge logic
// updates the running bar and pushes 0, 1 or 2 result words into a
// four-word queue; a result passes through both before it is offered.
// One input word is taken per cycle while the queue has room for the held
// word's results; the output side delivers one word per cycle while
// m_ready is high. When the receiver stalls the queue fills and s_ready
// drops once the held word's results no longer fit.
// Reset clears the queue, the input valid flag and the open-period flag and
// sets the interval to 60 s.
// ============================================================================
module ohlc_bar_resampler_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ohlc_pkg::IVL_BITS-1:0]        cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ohlc_pkg::TIME_BITS-1:0]       s_bar_time,
    input  logic [ohlc_pkg::PRICE_BITS-1:0]      s_open_price,
    input  logic [ohlc_pkg::PRICE_BITS-1:0]      s_high_price,
    input  logic [ohlc_pkg::PRICE_BITS-1:0]      s_low_price,
    input  logic [ohlc_pkg::PRICE_BITS-1:0]      s_close_price,
    input  logic [ohlc_pkg::IN_VOL_BITS-1:0]     s_traded_volume,
    input  logic                                 s_end_of_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ohlc_pkg::TIME_BITS-1:0]       m_period_time,
    output logic [ohlc_pkg::PRICE_BITS-1:0]      m_agg_open,
    output logic [ohlc_pkg::PRICE_BITS-1:0]      m_agg_high,
    output logic [ohlc_pkg::PRICE_BITS-1:0]      m_agg_low,
    output logic [ohlc_pkg::PRICE_BITS-1:0]      m_agg_close,
    output logic [ohlc_pkg::VOLUME_BITS-1:0]     m_agg_volume,
    output logic                                 m_series_done,
    output logic                                 m_run_last
);

    logic [ohlc_pkg::IVL_BITS-1:0]   ivl_reg;
    logic                            in_vld_reg;
    ohlc_pkg::bar_t                  bar_reg;
    ohlc_pkg::bar_t                  bar_in;
    logic                            fire;
    logic [1:0]                      res_cnt;
    ohlc_pkg::res_t                  res0;
    ohlc_pkg::res_t                  res1;
    ohlc_pkg::res_t                  head;
    logic [ohlc_pkg::FIFO_CW-1:0]    q_count;
    logic                            pop;

    assign bar_in = '{bar_time:      s_bar_time,
                      open_price:    s_open_price,
                      high_price:    s_high_price,
                      low_price:     s_low_price,
                      close_price:   s_close_price,
                      traded_volume: s_traded_volume,
                      end_of_data:   s_end_of_data};

    assign fire = in_vld_reg &&
                  ((q_count + ohlc_pkg::FIFO_CW'(res_cnt)) <=
                   ohlc_pkg::FIFO_CW'(ohlc_pkg::FIFO_DEPTH));
    assign s_ready = !in_vld_reg || fire;
    assign m_valid = (q_count != '0);
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ivl_reg <= ohlc_pkg::IVL_RESET;
        end else if (cfg_wr_en) begin
            ivl_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            bar_reg <= bar_in;
        end
    end

    ohlc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .interval (ivl_reg),
        .bar      (bar_reg),
        .fire     (fire),
        .res_cnt  (res_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    ohlc_res_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (fire ? res_cnt : 2'd0),
        .din0     (res0),
        .din1     (res1),
        .pop      (pop),
        .count    (q_count),
        .dout     (head)
    );

    assign m_period_time = head.period_time;
    assign m_agg_open    = head.agg_open;
    assign m_agg_high    = head.agg_high;
    assign m_agg_low     = head.agg_low;
    assign m_agg_close   = head.agg_close;
    assign m_agg_volume  = head.agg_volume;
    assign m_series_done = head.series_done;
    assign m_run_last    = head.run_last;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_vld_reg) |-> s_ready)
        else $error("input stalled with empty input register");

    a_hold_until_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !fire) |=> in_vld_reg)
        else $error("held input word dropped without processing");

endmodule

[verif/ohlc_bar_resampler_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// ohlc_bar_resampler_top_tb
// Self-checking bench for the OHLC bar resampler.
// ============================================================================
// A queue of bars feeds a valid/ready driver; a monitor takes result words
// and checks each against a bar aggregator kept in the bench. Directed bars
// cover merge, roll-over, flush, pass-through, limit saturation and
// inverted bars. A long run of full-volume bars merges into one large
// volume sum, and random series run under several intervals. Both sides
// idle at random, and one phase holds the receiver off to back up the block.
// ============================================================================
module ohlc_bar_resampler_top_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int VOL_BARS    = 200;
    localparam logic [ohlc_pkg::IVL_BITS-1:0]   IVL_TOP  = '1;
    localparam logic [ohlc_pkg::TIME_BITS-1:0]  TIME_TOP = '1;
    localparam logic [ohlc_pkg::PRICE_BITS-1:0] PX_TOP   = '1;

    logic                             aclk            = 1'b0;
    logic                             aresetn         = 1'b0;
    logic                             cfg_wr_en       = 1'b0;
    logic [ohlc_pkg::IVL_BITS-1:0]    cfg_wr_data     = '0;
    logic                             s_valid         = 1'b0;
    logic                             s_ready;
    logic [ohlc_pkg::TIME_BITS-1:0]   s_bar_time      = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  s_open_price    = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  s_high_price    = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  s_low_price     = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  s_close_price   = '0;
    logic [ohlc_pkg::IN_VOL_BITS-1:0] s_traded_volume = '0;
    logic                             s_end_of_data   = 1'b0;
    logic                             m_valid;
    logic                             m_ready         = 1'b0;
    logic [ohlc_pkg::TIME_BITS-1:0]   m_period_time;
    logic [ohlc_pkg::PRICE_BITS-1:0]  m_agg_open;
    logic [ohlc_pkg::PRICE_BITS-1:0]  m_agg_high;
    logic [ohlc_pkg::PRICE_BITS-1:0]  m_agg_low;
    logic [ohlc_pkg::PRICE_BITS-1:0]  m_agg_close;
    logic [ohlc_pkg::VOLUME_BITS-1:0] m_agg_volume;
    logic                             m_series_done;
    logic                             m_run_last;

    ohlc_bar_resampler_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_bar_time      (s_bar_time),
        .s_open_price    (s_open_price),
        .s_high_price    (s_high_price),
        .s_low_price     (s_low_price),
        .s_close_price   (s_close_price),
        .s_traded_volume (s_traded_volume),
        .s_end_of_data   (s_end_of_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_period_time   (m_period_time),
        .m_agg_open      (m_agg_open),
        .m_agg_high      (m_agg_high),
        .m_agg_low       (m_agg_low),
        .m_agg_close     (m_agg_close),
        .m_agg_volume    (m_agg_volume),
        .m_series_done   (m_series_done),
        .m_run_last      (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bench copy of the aggregator
    logic [ohlc_pkg::IVL_BITS-1:0]    ivl_cfg    = ohlc_pkg::IVL_RESET;
    logic                             run_active = 1'b0;
    logic [ohlc_pkg::TIME_BITS-1:0]   run_begin  = '0;
    logic [ohlc_pkg::TIME_BITS-1:0]   run_limit  = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  run_o      = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  run_h      = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  run_l      = '0;
    logic [ohlc_pkg::PRICE_BITS-1:0]  run_c      = '0;
    logic [ohlc_pkg::VOLUME_BITS-1:0] run_vol    = '0;

    ohlc_pkg::bar_t pending_bars[$];
    ohlc_pkg::res_t due_bars[$];

    ohlc_pkg::bar_t tx_bar;
    ohlc_pkg::res_t got_bar;
    ohlc_pkg::res_t want_bar;
    int   tx_wait     = 0;
    int   rx_wait     = 0;
    bit   tx_idle_en  = 1'b1;
    bit   rx_idle_en  = 1'b1;
    int   hold_req    = 0;
    int   hold_seen   = 0;
    int   hold_cnt    = 0;
    int   errors      = 0;
    int   cycle_cnt   = 0;

    function automatic ohlc_pkg::bar_t mk_bar(
        input logic [ohlc_pkg::TIME_BITS-1:0]   t,
        input logic [ohlc_pkg::PRICE_BITS-1:0]  o,
        input logic [ohlc_pkg::PRICE_BITS-1:0]  h,
        input logic [ohlc_pkg::PRICE_BITS-1:0]  l,
        input logic [ohlc_pkg::PRICE_BITS-1:0]  c,
        input logic [ohlc_pkg::IN_VOL_BITS-1:0] v,
        input logic                             eod);
        ohlc_pkg::bar_t b;
        b.bar_time      = t;
        b.open_price    = o;
        b.high_price    = h;
        b.low_price     = l;
        b.close_price   = c;
        b.traded_volume = v;
        b.end_of_data   = eod;
        return b;
    endfunction

    function automatic logic [ohlc_pkg::TIME_BITS-1:0] limit_after(
        input logic [ohlc_pkg::TIME_BITS-1:0] t);
        logic [ohlc_pkg::TIME_BITS:0] sum;
        sum = {1'b0, t} + (ohlc_pkg::TIME_BITS+1)'(ivl_cfg);
        return sum[ohlc_pkg::TIME_BITS] ? TIME_TOP : sum[ohlc_pkg::TIME_BITS-1:0];
    endfunction

    function automatic ohlc_pkg::res_t run_word(input logic done);
        ohlc_pkg::res_t w;
        w.period_time = run_begin;
        w.agg_open    = run_o;
        w.agg_high    = run_h;
        w.agg_low     = run_l;
        w.agg_close   = run_c;
        w.agg_volume  = run_vol;
        w.series_done = done;
        w.run_last    = 1'b0;
        return w;
    endfunction

    function automatic string fmt_bar(input ohlc_pkg::res_t r);
        return $sformatf("t=%0d o=%0d h=%0d l=%0d c=%0d v=%0d done=%0b last=%0b",
                         r.period_time, r.agg_open, r.agg_high, r.agg_low,
                         r.agg_close, r.agg_volume, r.series_done, r.run_last);
    endfunction

    task automatic add_bar(input ohlc_pkg::bar_t b);
        pending_bars = {pending_bars, b};
    endtask

    task automatic seed_run(input ohlc_pkg::bar_t b);
        run_o   = b.open_price;
        run_h   = b.high_price;
        run_l   = b.low_price;
        run_c   = b.close_price;
        run_vol = ohlc_pkg::VOLUME_BITS'(b.traded_volume);
    endtask

    task automatic merge_bar(input ohlc_pkg::bar_t b);
        ohlc_pkg::res_t                 words[$];
        ohlc_pkg::res_t                 w;
        logic [ohlc_pkg::VOLUME_BITS:0] vsum;
        if (ivl_cfg == '0) begin
            if (run_active) begin
                words = {words, run_word(1'b0)};
                run_active = 1'b0;
            end
            w.period_time = b.bar_time;
            w.agg_open    = b.open_price;
            w.agg_high    = b.high_price;
            w.agg_low     = b.low_price;
            w.agg_close   = b.close_price;
            w.agg_volume  = ohlc_pkg::VOLUME_BITS'(b.traded_volume);
            w.series_done = b.end_of_data;
            w.run_last    = 1'b0;
            words = {words, w};
        end else if (!run_active) begin
            run_active = 1'b1;
            run_begin  = b.bar_time;
            run_limit  = limit_after(b.bar_time);
            seed_run(b);
        end else if (b.bar_time < run_limit) begin
            if (b.high_price > run_h) run_h = b.high_price;
            if (b.low_price < run_l) run_l = b.low_price;
            run_c = b.close_price;
            vsum = {1'b0, run_vol} + (ohlc_pkg::VOLUME_BITS+1)'(b.traded_volume);
            run_vol = vsum[ohlc_pkg::VOLUME_BITS] ? '1 : vsum[ohlc_pkg::VOLUME_BITS-1:0];
        end else begin
            words = {words, run_word(1'b0)};
            run_begin = run_limit;
            run_limit = limit_after(run_begin);
            seed_run(b);
        end
        if (ivl_cfg != '0 && b.end_of_data && run_active) begin
            words = {words, run_word(1'b1)};
            run_active = 1'b0;
        end
        if (words.size() > 0) words[words.size()-1].run_last = 1'b1;
        foreach (words[i]) due_bars = {due_bars, words[i]};
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_valid && s_ready) merge_bar(tx_bar);
            if (!s_valid || s_ready) begin
                if (tx_wait != 0) begin
                    tx_wait = tx_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_bars.size() != 0) begin
                    tx_bar = pending_bars.pop_front();
                    s_bar_time      <= tx_bar.bar_time;
                    s_open_price    <= tx_bar.open_price;
                    s_high_price    <= tx_bar.high_price;
                    s_low_price     <= tx_bar.low_price;
                    s_close_price   <= tx_bar.close_price;
                    s_traded_volume <= tx_bar.traded_volume;
                    s_end_of_data   <= tx_bar.end_of_data;
                    s_valid         <= 1'b1;
                    tx_wait = tx_idle_en ? $urandom_range(0, 19) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_bar.period_time = m_period_time;
                got_bar.agg_open    = m_agg_open;
                got_bar.agg_high    = m_agg_high;
                got_bar.agg_low     = m_agg_low;
                got_bar.agg_close   = m_agg_close;
                got_bar.agg_volume  = m_agg_volume;
                got_bar.series_done = m_series_done;
                got_bar.run_last    = m_run_last;
                if (due_bars.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) $display("unexpected word: %s", fmt_bar(got_bar));
                end else begin
                    want_bar = due_bars.pop_front();
                    if (got_bar.period_time !== want_bar.period_time ||
                        got_bar.agg_open    !== want_bar.agg_open    ||
                        got_bar.agg_high    !== want_bar.agg_high    ||
                        got_bar.agg_low     !== want_bar.agg_low     ||
                        got_bar.agg_close   !== want_bar.agg_close   ||
                        got_bar.agg_volume  !== want_bar.agg_volume  ||
                        got_bar.series_done !== want_bar.series_done ||
                        got_bar.run_last    !== want_bar.run_last) begin
                        errors = errors + 1;
                        if (errors <= 10) begin
                            $display("mismatch exp: %s", fmt_bar(want_bar));
                            $display("         got: %s", fmt_bar(got_bar));
                        end
                    end
                end
                rx_wait = rx_idle_en ? $urandom_range(0, 19) : 0;
            end
            if (hold_cnt != 0) begin
                m_ready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("ohlc_bar_resampler_top test failed");
        $finish;
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_bars.size() != 0 || s_valid || due_bars.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_interval(input logic [ohlc_pkg::IVL_BITS-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ivl_cfg = v;
        @(negedge aclk);
    endtask

    task automatic gen_series(input logic [ohlc_pkg::IVL_BITS-1:0] span_ivl,
                              output int added);
        int                              n;
        int unsigned                     span;
        logic [ohlc_pkg::TIME_BITS-1:0]  t;
        logic [ohlc_pkg::PRICE_BITS-1:0] hi;
        logic [ohlc_pkg::PRICE_BITS-1:0] lo;
        ohlc_pkg::bar_t                  b;
        n    = $urandom_range(1, 12);
        span = (span_ivl == '0) ? 100 : 32'(span_ivl);
        if ($urandom_range(0, 3) == 0) t = ohlc_pkg::TIME_BITS'({$urandom, $urandom});
        else t = ohlc_pkg::TIME_BITS'($urandom_range(0, 100000));
        for (int k = 0; k < n; k++) begin
            b.bar_time = t;
            case ($urandom_range(0, 15))
                0: b.bar_time = ohlc_pkg::TIME_BITS'({$urandom, $urandom});
                1: b.bar_time = t - ohlc_pkg::TIME_BITS'($urandom_range(0, span));
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                b.open_price  = $urandom;
                b.high_price  = $urandom;
                b.low_price   = $urandom;
                b.close_price = $urandom;
            end else begin
                hi = $urandom;
                lo = $urandom_range(0, hi);
                b.high_price  = hi;
                b.low_price   = lo;
                b.open_price  = $urandom_range(lo, hi);
                b.close_price = $urandom_range(lo, hi);
            end
            case ($urandom_range(0, 3))
                0: b.traded_volume = $urandom_range(0, 1000);
                1: b.traded_volume = '1;
                default: b.traded_volume = $urandom;
            endcase
            if (k == n - 1) b.end_of_data = ($urandom_range(0, 7) != 0);
            else b.end_of_data = ($urandom_range(0, 31) == 0);
            add_bar(b);
            t = t + ohlc_pkg::TIME_BITS'($urandom_range(0, span * 2));
        end
        added = n;
    endtask

    initial begin
        int                            added;
        int                            queued;
        logic [ohlc_pkg::IVL_BITS-1:0] ivl_pick;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset interval of 60 s: merge, roll-over, flush, limit saturation, inverted bars
        add_bar(mk_bar(1000, 500, 600, 400, 550, '1, 0));
        add_bar(mk_bar(1010, 0, PX_TOP, 0, 123, '1, 0));
        add_bar(mk_bar(990, 1, 2, 3, 4, 0, 0));
        add_bar(mk_bar(1059, 7, 8, 6, 7, 5, 0));
        add_bar(mk_bar(1060, 10, 20, 5, 15, 100, 0));
        add_bar(mk_bar(5000, 30, 10, 40, 20, 1, 0));
        add_bar(mk_bar(1130, 31, 35, 29, 33, 2, 1));
        add_bar(mk_bar(5, 1, 1, 1, 1, 1, 1));
        add_bar(mk_bar(TIME_TOP - 10, PX_TOP, PX_TOP, PX_TOP, PX_TOP, '1, 0));
        add_bar(mk_bar(TIME_TOP, 0, 0, 0, 0, 0, 0));
        add_bar(mk_bar(0, 0, PX_TOP, 0, 0, 0, 0));
        add_bar(mk_bar(TIME_TOP, 9, 9, 9, 9, 9, 1));
        add_bar(mk_bar(50, 1, 2, 0, 1, 3, 0));

        // pass-through, first bar flushes the open period
        wait_idle();
        set_interval('0);
        add_bar(mk_bar(70, 4, 5, 3, 4, 6, 0));
        add_bar(mk_bar(TIME_TOP, PX_TOP, PX_TOP, PX_TOP, PX_TOP, '1, 1));
        add_bar(mk_bar(0, 0, 0, 0, 0, 0, 0));
        add_bar(mk_bar(123, 5, 1, 9, 3, 77, 1));

        // widest interval
        wait_idle();
        set_interval(IVL_TOP);
        add_bar(mk_bar(TIME_TOP - 100, 11, 12, 10, 11, 1, 0));
        add_bar(mk_bar(1, 13, 14, 2, 12, 2, 0));
        add_bar(mk_bar(TIME_TOP - 1, 15, 16, 14, 15, 3, 1));
        add_bar(mk_bar(0, 20, 25, 18, 22, 4, 0));
        add_bar(mk_bar(40'h7FFF_FFFE, 21, 26, 17, 23, 5, 0));
        add_bar(mk_bar(40'h7FFF_FFFF, 24, 27, 19, 24, 6, 1));

        // back-pressure: receiver held off while the sender keeps offering
        wait_idle();
        set_interval(7);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        hold_req   = hold_req + 1;
        queued = 0;
        while (queued < 60) begin
            gen_series(7, added);
            queued = queued + added;
        end

        // long merge of full-volume bars
        wait_idle();
        set_interval(IVL_TOP);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int k = 0; k < VOL_BARS; k++)
            add_bar(mk_bar(12345, $urandom, $urandom, $urandom, $urandom, '1, 0));
        add_bar(mk_bar(12346, $urandom, $urandom, $urandom, $urandom, '1, 1));

        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0: ivl_pick = '0;
                1: ivl_pick = 1;
                2: ivl_pick = 60;
                3: ivl_pick = IVL_TOP;
                4: ivl_pick = ohlc_pkg::IVL_BITS'($urandom_range(2, 600));
                default: ivl_pick = ohlc_pkg::IVL_BITS'($urandom);
            endcase
            wait_idle();
            set_interval(ivl_pick);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            queued = 0;
            while (queued < 140) begin
                gen_series(ivl_pick, added);
                queued = queued + added;
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && due_bars.size() == 0) begin
            $display("ohlc_bar_resampler_top test passed");
        end else begin
            $display("ohlc_bar_resampler_top test failed");
        end
        $finish;
    end

endmodule
